// ----- rtl/core/pzb_pkg.sv -----
// ----------------------------------------------------------------------------
// pzb_pkg
// Shared types, constants and tables for the projecting z-buffer plotter.
// ----------------------------------------------------------------------------
package pzb_pkg;

  localparam int SCREEN_W = 64;
  localparam int SCREEN_H = 32;
  localparam int CELLS    = SCREEN_W * SCREEN_H;
  localparam int CELL_AW  = $clog2(CELLS);
  localparam int COL_W    = $clog2(SCREEN_W);
  localparam int ROW_W    = $clog2(SCREEN_H);

  // configuration register indexes
  localparam logic [2:0] CFG_COS_FIRST    = 3'd0;
  localparam logic [2:0] CFG_SIN_FIRST    = 3'd1;
  localparam logic [2:0] CFG_COS_SECOND   = 3'd2;
  localparam logic [2:0] CFG_SIN_SECOND   = 3'd3;
  localparam logic [2:0] CFG_DEPTH_OFFSET = 3'd4;
  localparam logic [2:0] CFG_PROJ_SCALE   = 3'd5;
  localparam logic [2:0] CFG_LIGHTING_ON  = 3'd6;

  localparam logic [6:0] GLYPH_SPACE  = 7'd32;
  localparam logic [6:0] GLYPH_A      = 7'd97;
  localparam logic [6:0] SHADE_MAX    = 7'd11;
  localparam logic [2:0] FACE_LAST    = 3'd5;

  localparam logic [2:0] FACE_POS_Z = 3'd0;
  localparam logic [2:0] FACE_NEG_Z = 3'd1;
  localparam logic [2:0] FACE_POS_X = 3'd2;
  localparam logic [2:0] FACE_NEG_X = 3'd3;
  localparam logic [2:0] FACE_POS_Y = 3'd4;
  localparam logic [2:0] FACE_NEG_Y = 3'd5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ROT,
    ST_DEPTH,
    ST_DIV,
    ST_PROJ,
    ST_CHECK,
    ST_WRITE
  } state_e;

  // shade ramp ".,-~:;=!*#$@"
  function automatic logic [6:0] shade_glyph(input logic [3:0] s);
    logic [6:0] g;
    case (s)
      4'd0:    g = 7'd46;
      4'd1:    g = 7'd44;
      4'd2:    g = 7'd45;
      4'd3:    g = 7'd126;
      4'd4:    g = 7'd58;
      4'd5:    g = 7'd59;
      4'd6:    g = 7'd61;
      4'd7:    g = 7'd33;
      4'd8:    g = 7'd42;
      4'd9:    g = 7'd35;
      4'd10:   g = 7'd36;
      default: g = 7'd64;
    endcase
    return g;
  endfunction

endpackage

// ----- rtl/core/point_project_zbuffer_plot.sv -----
// ----------------------------------------------------------------------------
// point_project_zbuffer_plot
// Rotates, projects and depth-tests cube points into a glyph/depth store.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on mode_i and the field ports with start high; it is taken
//   at a rising edge where busy is low. A plot item (mode 0) returns nothing.
//   A read item (mode 1) returns the cell glyph on glyph_o with res_valid_o
//   high for exactly one cycle, the cycle after acceptance, and clears the
//   cell. The receiver cannot stall; every strobe is a delivered item.
//   A plot item holds busy until it is done, so no new item is taken
//   before then: 8 multiply-accumulate steps for the two rotations,
//   one depth step, 16 steps of the bit-serial reciprocal (skipped when
//   it saturates), 5 projection multiply steps, then a read and a write
//   of the cell store. A discarded point (unlit face, bad face) is
//   dropped at acceptance with busy staying low; non-positive depth or
//   off screen ends early.
//   One shared 22x17 multiplier serves the rotation and projection steps,
//   and the cell store has one read port and one write port.
//   Configuration goes through cfg_valid_i/cfg_ready_o; ready is always high.
//   After reset every cell of the store is swept to empty, one cell a
//   cycle, with busy high; configuration writes are still taken then.
// ----------------------------------------------------------------------------
module point_project_zbuffer_plot (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                mode_i,
  input  logic signed [15:0]  pos_x_i,
  input  logic signed [15:0]  pos_y_i,
  input  logic signed [15:0]  pos_z_i,
  input  logic [2:0]          face_i,
  input  logic [5:0]          cell_col_i,
  input  logic [4:0]          cell_row_i,
  output logic                res_valid_o,
  output logic [6:0]          glyph_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  localparam int AW = pzb_pkg::CELL_AW;

  // configuration
  logic signed [15:0] cos_first_q, sin_first_q, cos_second_q, sin_second_q;
  logic [15:0]        depth_offset_q, proj_scale_q;
  logic               lighting_on_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_first_q    <= 16'sd16384;
      sin_first_q    <= 16'sd0;
      cos_second_q   <= 16'sd16384;
      sin_second_q   <= 16'sd0;
      depth_offset_q <= 16'd2560;
      proj_scale_q   <= 16'd12800;
      lighting_on_q  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pzb_pkg::CFG_COS_FIRST:    cos_first_q    <= cfg_data_i;
        pzb_pkg::CFG_SIN_FIRST:    sin_first_q    <= cfg_data_i;
        pzb_pkg::CFG_COS_SECOND:   cos_second_q   <= cfg_data_i;
        pzb_pkg::CFG_SIN_SECOND:   sin_second_q   <= cfg_data_i;
        pzb_pkg::CFG_DEPTH_OFFSET: depth_offset_q <= cfg_data_i;
        pzb_pkg::CFG_PROJ_SCALE:   proj_scale_q   <= cfg_data_i;
        pzb_pkg::CFG_LIGHTING_ON:  lighting_on_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // control and datapath registers
  pzb_pkg::state_e    state_q, state_d;
  logic [3:0]         step_q, step_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic signed [15:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [6:0]         glyph_q, glyph_d;
  logic signed [18:0] u_q, u_d, rz_q, rz_d;
  logic signed [20:0] rx_q, rx_d, ry_q, ry_d;
  logic signed [55:0] acc_q, acc_d;
  logic [20:0]        dv_q, dv_d, rem_q, rem_d;
  logic [15:0]        ooz_q, ooz_d;
  logic [31:0]        k_q, k_d;
  logic signed [20:0] col_q, col_d, row_q, row_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic               oob_q, oob_d;
  logic               rd_q, rd_d;

  // cell store: inverse depth in [22:7], glyph in [6:0]
  logic [22:0]        mem [pzb_pkg::CELLS];
  logic [22:0]        rdata_q;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr, mem_raddr;
  logic [22:0]        mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  // shared multiply-accumulate
  logic signed [21:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [38:0] prod;
  logic               acc_clr, acc_shift;
  logic signed [55:0] acc_base, acc_sum, sh14, sh36;

  assign prod     = mul_a * mul_b;
  assign acc_base = acc_shift ? (acc_q <<< 16) : (acc_clr ? 56'sd0 : acc_q);
  assign acc_sum  = acc_base + 56'(prod);
  assign sh14     = acc_sum >>> 14;
  assign sh36     = acc_sum >>> 36;

  // face light and glyph at acceptance
  logic signed [16:0] light;
  logic signed [20:0] light11;
  logic [6:0]         shade;
  logic [6:0]         new_glyph;
  logic               drop_pt;

  always_comb begin
    case (face_i)
      pzb_pkg::FACE_POS_Z: light = -17'(cos_first_q);
      pzb_pkg::FACE_NEG_Z: light = 17'(cos_first_q);
      pzb_pkg::FACE_POS_Y: light = -17'(sin_first_q);
      pzb_pkg::FACE_NEG_Y: light = 17'(sin_first_q);
      default:             light = 17'sd0;
    endcase
    light11 = 21'(light) * 21'sd11;
    shade   = light11[20:14];
    if (shade > pzb_pkg::SHADE_MAX) begin
      shade = pzb_pkg::SHADE_MAX;
    end
    if (lighting_on_q) begin
      new_glyph = pzb_pkg::shade_glyph(shade[3:0]);
    end else begin
      new_glyph = pzb_pkg::GLYPH_A + 7'(face_i);
    end
    drop_pt = (face_i > pzb_pkg::FACE_LAST) || (lighting_on_q && (light <= 17'sd0));
  end

  logic signed [21:0] depth;
  logic [21:0]        rem_sh;
  logic               rem_ge;
  logic [AW-1:0]      rd_idx, pt_idx;

  assign depth  = 22'(rz_q) + $signed({2'b00, depth_offset_q, 4'b0000});
  assign rem_sh = {rem_q, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, dv_q};
  assign rd_idx = AW'(cell_row_i) * AW'(pzb_pkg::SCREEN_W) + AW'(cell_col_i);
  assign pt_idx = AW'(row_q[pzb_pkg::ROW_W-1:0]) * AW'(pzb_pkg::SCREEN_W)
                + AW'(col_q[pzb_pkg::COL_W-1:0]);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    clr_d   = clr_q;
    x_d = x_q; y_d = y_q; z_d = z_q;
    glyph_d = glyph_q;
    u_d = u_q; rz_d = rz_q; rx_d = rx_q; ry_d = ry_q;
    acc_d   = acc_q;
    dv_d    = dv_q;
    rem_d   = rem_q;
    ooz_d   = ooz_q;
    k_d     = k_q;
    col_d   = col_q;
    row_d   = row_q;
    idx_d   = idx_q;
    oob_d   = oob_q;
    rd_d    = rd_q;
    mul_a     = 22'sd0;
    mul_b     = 17'sd0;
    acc_clr   = 1'b1;
    acc_shift = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = {16'd0, pzb_pkg::GLYPH_SPACE};
    mem_raddr = idx_q;
    busy        = 1'b1;
    res_valid_o = 1'b0;
    glyph_o     = pzb_pkg::GLYPH_SPACE;

    case (state_q)
      pzb_pkg::ST_CLEAR: begin
        // sweep the store to empty after reset
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(pzb_pkg::CELLS - 1)) begin
          state_d = pzb_pkg::ST_IDLE;
        end
      end

      pzb_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (mode_i) begin
            // read and clear: fetch the cell now, answer next cycle
            oob_d     = (32'(cell_col_i) >= pzb_pkg::SCREEN_W)
                     || (32'(cell_row_i) >= pzb_pkg::SCREEN_H);
            idx_d     = rd_idx;
            mem_raddr = rd_idx;
            rd_d      = 1'b1;
            state_d   = pzb_pkg::ST_WRITE;
          end else if (!drop_pt) begin
            x_d = pos_x_i; y_d = pos_y_i; z_d = pos_z_i;
            glyph_d = new_glyph;
            rd_d    = 1'b0;
            step_d  = 4'd0;
            state_d = pzb_pkg::ST_ROT;
          end
        end
      end

      pzb_pkg::ST_ROT: begin
        step_d = step_q + 4'd1;
        case (step_q[2:0])
          3'd0: begin mul_a = 22'(y_q); mul_b = 17'(cos_first_q); end
          3'd1: begin
            mul_a = 22'(z_q); mul_b = -17'(sin_first_q); acc_clr = 1'b0;
            u_d = sh14[18:0];
          end
          3'd2: begin mul_a = 22'(y_q); mul_b = 17'(sin_first_q); end
          3'd3: begin
            mul_a = 22'(z_q); mul_b = 17'(cos_first_q); acc_clr = 1'b0;
            rz_d = sh14[18:0];
          end
          3'd4: begin mul_a = 22'(x_q); mul_b = 17'(cos_second_q); end
          3'd5: begin
            mul_a = 22'(u_q); mul_b = -17'(sin_second_q); acc_clr = 1'b0;
            rx_d = sh14[20:0];
          end
          3'd6: begin mul_a = 22'(u_q); mul_b = 17'(cos_second_q); end
          default: begin
            mul_a = 22'(x_q); mul_b = 17'(sin_second_q); acc_clr = 1'b0;
            ry_d = sh14[20:0];
            state_d = pzb_pkg::ST_DEPTH;
          end
        endcase
      end

      pzb_pkg::ST_DEPTH: begin
        step_d = 4'd0;
        if (depth <= 22'sd0) begin
          state_d = pzb_pkg::ST_IDLE;
        end else if (depth <= 22'sd4096) begin
          // reciprocal saturates
          ooz_d   = 16'hFFFF;
          state_d = pzb_pkg::ST_PROJ;
        end else begin
          dv_d    = depth[20:0];
          rem_d   = 21'd4096;
          state_d = pzb_pkg::ST_DIV;
        end
      end

      pzb_pkg::ST_DIV: begin
        // one quotient bit per cycle of 2^28 / depth
        rem_d  = rem_ge ? 21'(rem_sh - {1'b0, dv_q}) : rem_sh[20:0];
        ooz_d  = {ooz_q[14:0], rem_ge};
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) begin
          step_d  = 4'd0;
          state_d = pzb_pkg::ST_PROJ;
        end
      end

      pzb_pkg::ST_PROJ: begin
        step_d = step_q + 4'd1;
        case (step_q[2:0])
          3'd0: begin
            mul_a = $signed({6'd0, proj_scale_q});
            mul_b = $signed({1'b0, ooz_q});
            k_d   = acc_sum[31:0];
          end
          3'd1: begin mul_a = 22'(rx_q); mul_b = $signed({1'b0, k_q[31:16]}); end
          3'd2: begin
            mul_a = 22'(rx_q); mul_b = $signed({1'b0, k_q[15:0]}); acc_shift = 1'b1;
            col_d = sh36[20:0] + 21'(pzb_pkg::SCREEN_W / 2);
          end
          3'd3: begin mul_a = -22'(ry_q); mul_b = $signed({1'b0, k_q[31:16]}); end
          default: begin
            mul_a = -22'(ry_q); mul_b = $signed({1'b0, k_q[15:0]}); acc_shift = 1'b1;
            row_d   = sh36[20:0] + 21'(pzb_pkg::SCREEN_H / 2);
            state_d = pzb_pkg::ST_CHECK;
          end
        endcase
      end

      pzb_pkg::ST_CHECK: begin
        // drop off-screen points, else fetch the cell
        if (col_q < 21'sd0 || col_q >= 21'(pzb_pkg::SCREEN_W)
            || row_q < 21'sd0 || row_q >= 21'(pzb_pkg::SCREEN_H)) begin
          state_d = pzb_pkg::ST_IDLE;
        end else begin
          idx_d     = pt_idx;
          mem_raddr = pt_idx;
          state_d   = pzb_pkg::ST_WRITE;
        end
      end

      pzb_pkg::ST_WRITE: begin
        state_d = pzb_pkg::ST_IDLE;
        if (rd_q) begin
          res_valid_o = 1'b1;
          glyph_o     = oob_q ? pzb_pkg::GLYPH_SPACE : rdata_q[6:0];
          mem_we      = !oob_q;
        end else if (rdata_q[22:7] < ooz_q) begin
          // nearer than stored point: take the cell
          mem_we    = 1'b1;
          mem_wdata = {ooz_q, glyph_q};
        end
      end

      default: state_d = pzb_pkg::ST_IDLE;
    endcase
    if (state_q == pzb_pkg::ST_ROT || state_q == pzb_pkg::ST_PROJ) begin
      acc_d = acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pzb_pkg::ST_CLEAR;
      step_q  <= 4'd0;
      clr_q   <= '0;
      rd_q    <= 1'b0;
      oob_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      clr_q   <= clr_d;
      rd_q    <= rd_d;
      oob_q   <= oob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; y_q <= y_d; z_q <= z_d;
    glyph_q <= glyph_d;
    u_q <= u_d; rz_q <= rz_d; rx_q <= rx_d; ry_q <= ry_d;
    acc_q <= acc_d;
    dv_q  <= dv_d;
    rem_q <= rem_d;
    ooz_q <= ooz_d;
    k_q   <= k_d;
    col_q <= col_d;
    row_q <= row_d;
    idx_q <= idx_d;
  end

endmodule

// ----- rtl/core/pzb_chk.sv -----
// ----------------------------------------------------------------------------
// pzb_chk
// Port-level checks for the z-buffer plotter, bound to the top level.
// ----------------------------------------------------------------------------
module pzb_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       mode_i,
  input logic       res_valid_o,
  input logic [6:0] glyph_o
);

  // a read item answers in the very next cycle
  a_read_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && mode_i |=> res_valid_o)
    else $error("read item gave no result");

  // a plot item never answers
  a_plot_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !mode_i |=> !res_valid_o)
    else $error("plot item gave a result");

  // strobes are single cycles while the item is held
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy ##1 !res_valid_o)
    else $error("result strobe too long or outside busy");

  // stored glyphs are always printable
  a_glyph_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> glyph_o >= 7'd32)
    else $error("result glyph not printable");

endmodule

bind point_project_zbuffer_plot pzb_chk u_pzb_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .mode_i      (mode_i),
  .res_valid_o (res_valid_o),
  .glyph_o     (glyph_o)
);
